@@ rtl/core/pfb_pkg.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer package
// Shared codes, configuration record and controller/datapath handshake types.
// ----------------------------------------------------------------------------
package pfb_pkg;

    // Input beat operation codes
    typedef enum logic [1:0] {
        CMD_PIXEL = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_TICK  = 2'd3
    } t_command;

    // Pixel write operations
    typedef enum logic [1:0] {
        COL_CLEAR  = 2'd0,
        COL_SET    = 2'd1,
        COL_TOGGLE = 2'd2,
        COL_KEEP   = 2'd3
    } t_colour;

    // Coordinate rotation codes
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } t_rotation;

    // Flush sequence within one page row
    typedef enum logic [1:0] {
        PH_COL_LOW  = 2'd0,
        PH_COL_HIGH = 2'd1,
        PH_PAGE     = 2'd2,
        PH_DATA     = 2'd3
    } t_phase;

    // Register file geometry and indexes
    localparam int REG_ADDR_W = 5;
    localparam int REG_DATA_W = 32;

    localparam logic [2:0] REG_ROTATION      = 3'd0;
    localparam logic [2:0] REG_X_OFFSET      = 3'd1;
    localparam logic [2:0] REG_Y_OFFSET      = 3'd2;
    localparam logic [2:0] REG_COL_LOW_CODE  = 3'd3;
    localparam logic [2:0] REG_COL_HIGH_CODE = 3'd4;
    localparam logic [2:0] REG_PAGE_CODE     = 3'd5;

    // Configuration; offsets are two's complement
    typedef struct packed {
        logic [1:0] rotation;
        logic [8:0] x_offset;
        logic [7:0] y_offset;
        logic [7:0] col_low_code;
        logic [7:0] col_high_code;
        logic [7:0] page_code;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic pix_issue;    // read target byte of an accepted pixel write
        logic pix_commit;   // write back modified byte
        logic clr_step;     // zero one store byte
        logic flush_start;  // arm the readout
        logic tick_issue;   // read store byte for the current flush position
        logic tick_emit;    // load output register, advance flush position
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pix_hit;       // pixel in bounds and colour is not keep
        logic clr_last;      // clear pointer at the final byte
        logic flush_active;
        logic out_free;      // output register can take a beat
    } t_dp_stat;

endpackage

@@ rtl/core/page_framebuffer_pixel_and_flush.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer with pixel write and panel flush
// Monochrome page-organized frame store (eight vertical pixels per byte) with
// rotated pixel writes, store clear and a byte-per-tick panel readout.
// ----------------------------------------------------------------------------
// One beat is handled at a time, all through a single frame store with one
// write and one registered read port. A pixel write that lands in bounds with
// a colour other than keep is done as a store read, then a modified write-back;
// one that is ignored, a start-flush and a tick while no flush is running are
// taken without a further state. A flush tick is done as a store read, then a
// load of the output register, and is held between the two while the output
// beat ahead of it is still stalled. A clear runs a clearing pass over WIDTH *
// ceil(HEIGHT / 8) store bytes, one store byte per cycle; the same pass runs
// after reset, and no input beat is taken until it ends. Configuration
// registers are to be written only while no input beat is in progress.
module page_framebuffer_pixel_and_flush #(
    parameter int WIDTH  = 192,
    parameter int HEIGHT = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfb_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [pfb_pkg::REG_DATA_W-1:0]   pwdata,
    output logic [pfb_pkg::REG_DATA_W-1:0]   prdata,
    output logic                             pready,
    // input beats
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [1:0]                       i_command,
    input  logic [9:0]                       i_pixel_x,
    input  logic [9:0]                       i_pixel_y,
    input  logic [1:0]                       i_colour,
    // output beats
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [7:0]                       o_out_byte,
    output logic                             o_is_command,
    output logic                             o_last
);
    import pfb_pkg::*;

    t_cfg     w_cfg;
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    pfb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pfb_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .i_stat    (w_stat),
        .o_stall   (o_stall),
        .o_cmd     (w_cmd)
    );

    pfb_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_colour     (i_colour),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_out_byte   (o_out_byte),
        .o_is_command (o_is_command),
        .o_last       (o_last)
    );

endmodule

@@ rtl/core/pfb_regs.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer configuration registers
// APB-style register file holding rotation, flush offsets and command codes.
// ----------------------------------------------------------------------------
module pfb_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [pfb_pkg::REG_ADDR_W-1:0]   paddr,
    input  logic [pfb_pkg::REG_DATA_W-1:0]   pwdata,
    output logic [pfb_pkg::REG_DATA_W-1:0]   prdata,
    output logic                             pready,
    output pfb_pkg::t_cfg                    o_cfg
);
    import pfb_pkg::*;

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_idx  = paddr[4:2];
    assign o_cfg  = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotation      <= 2'd0;
            r_cfg.x_offset      <= 9'd0;
            r_cfg.y_offset      <= 8'd0;
            r_cfg.col_low_code  <= 8'h00;
            r_cfg.col_high_code <= 8'h10;
            r_cfg.page_code     <= 8'hB0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ROTATION:      r_cfg.rotation      <= pwdata[1:0];
                REG_X_OFFSET:      r_cfg.x_offset      <= pwdata[8:0];
                REG_Y_OFFSET:      r_cfg.y_offset      <= pwdata[7:0];
                REG_COL_LOW_CODE:  r_cfg.col_low_code  <= pwdata[7:0];
                REG_COL_HIGH_CODE: r_cfg.col_high_code <= pwdata[7:0];
                REG_PAGE_CODE:     r_cfg.page_code     <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Readback
    always_comb begin
        unique case (w_idx)
            REG_ROTATION:      prdata = {30'd0, r_cfg.rotation};
            REG_X_OFFSET:      prdata = {23'd0, r_cfg.x_offset};
            REG_Y_OFFSET:      prdata = {24'd0, r_cfg.y_offset};
            REG_COL_LOW_CODE:  prdata = {24'd0, r_cfg.col_low_code};
            REG_COL_HIGH_CODE: prdata = {24'd0, r_cfg.col_high_code};
            REG_PAGE_CODE:     prdata = {24'd0, r_cfg.page_code};
            default:           prdata = '0;
        endcase
    end

endmodule

@@ rtl/core/pfb_ctrl.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer controller
// Sequences clearing, pixel read-modify-write and flush beats over the datapath.
// ----------------------------------------------------------------------------
module pfb_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_command,
    input  pfb_pkg::t_dp_stat i_stat,
    output logic              o_stall,
    output pfb_pkg::t_dp_cmd  o_cmd
);
    import pfb_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_WRITE = 4'b0100,
        S_TICK  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_command)
                        CMD_PIXEL: begin
                            if (i_stat.pix_hit) begin
                                o_cmd.pix_issue = 1'b1;
                                n_state         = S_WRITE;
                            end
                        end
                        CMD_CLEAR: begin
                            n_state = S_CLEAR;
                        end
                        CMD_FLUSH: begin
                            o_cmd.flush_start = 1'b1;
                        end
                        CMD_TICK: begin
                            if (i_stat.flush_active) begin
                                o_cmd.tick_issue = 1'b1;
                                n_state          = S_TICK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_WRITE: begin
                o_cmd.pix_commit = 1'b1;
                n_state          = S_IDLE;
            end
            S_TICK: begin
                // hold the read byte until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.tick_emit = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

    // Assertions
    a_write_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE) |-> $past(o_cmd.pix_issue))
        else $error("write-back state without a pixel read");

    a_tick_after_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TICK && $past(r_state) != S_TICK) |-> $past(o_cmd.tick_issue))
        else $error("tick state entered without a store read");

    a_clear_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR && i_stat.clr_last) |=> (r_state == S_IDLE))
        else $error("clearing pass did not end at the last byte");

endmodule

@@ rtl/core/pfb_datapath.sv @@
// ----------------------------------------------------------------------------
// Page framebuffer datapath
// Frame store, pixel address mapping, flush position tracking, output register.
// ----------------------------------------------------------------------------
module pfb_datapath #(
    parameter int WIDTH  = 192,
    parameter int HEIGHT = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pfb_pkg::t_cfg     i_cfg,
    input  pfb_pkg::t_dp_cmd  i_cmd,
    output pfb_pkg::t_dp_stat o_stat,
    input  logic [9:0]        i_pixel_x,
    input  logic [9:0]        i_pixel_y,
    input  logic [1:0]        i_colour,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_is_command,
    output logic              o_last
);
    import pfb_pkg::*;

    localparam int NPAGES     = (HEIGHT + 7) / 8;
    localparam int STORE_SIZE = WIDTH * NPAGES;
    localparam int AW         = $clog2(STORE_SIZE);

    localparam logic [9:0]    W10      = 10'(WIDTH);
    localparam logic [9:0]    H10      = 10'(HEIGHT);
    localparam logic [11:0]   W12      = 12'(WIDTH);
    localparam logic [5:0]    NPAGES6  = 6'(NPAGES);
    localparam logic [AW-1:0] CLR_LAST = AW'(STORE_SIZE - 1);

    // Frame store
    logic [7:0]    r_mem [STORE_SIZE];
    logic [7:0]    r_rd_data;
    logic          w_we;
    logic          w_re;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    logic [7:0]    w_wdata;

    // Clear sweep
    logic [AW-1:0] r_clr_addr;

    // Pixel write
    logic          w_swap;
    logic [9:0]    w_lw;
    logic [9:0]    w_lh;
    logic          w_in_bounds;
    logic [9:0]    w_px;
    logic [9:0]    w_py;
    logic [11:0]   w_pix_sum;
    logic [AW-1:0] w_pix_idx;
    logic [7:0]    w_pix_mask;
    logic [AW-1:0] r_pix_addr;
    logic [7:0]    r_pix_mask;
    logic [1:0]    r_pix_colour;
    logic [7:0]    w_modified;

    // Flush position
    logic          r_flush_active;
    logic [3:0]    r_row;
    logic [7:0]    r_col;
    logic [1:0]    r_phase;
    logic [3:0]    r_page_cnt;

    // Flush geometry
    logic          w_yo_neg;
    logic [8:0]    w_yo_mag;
    logic [8:0]    w_rlo_sum;
    logic [4:0]    w_rlo;
    logic [9:0]    w_hdiff;
    logic [9:0]    w_hceil_sum;
    logic [5:0]    w_hceil;
    logic [5:0]    w_rend;
    logic          w_start_ok;
    logic [3:0]    w_page_start;
    logic          w_xo_neg;
    logic [8:0]    w_clo;
    logic [9:0]    w_chi;
    logic [7:0]    w_col_addr;
    logic [8:0]    w_from;
    logic [8:0]    w_c;
    logic          w_c_ok;
    logic [4:0]    w_rnext;
    logic          w_r_ok;
    logic          w_last;
    logic [11:0]   w_fl_sum;
    logic [AW-1:0] w_fl_idx;
    logic [7:0]    w_byte;
    logic          w_is_cmd;

    // Output register
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_cmd;
    logic          r_out_last;

    // ------------------------------------------------------------------
    // Pixel coordinate check and rotation
    // ------------------------------------------------------------------
    assign w_swap      = i_cfg.rotation[0];
    assign w_lw        = w_swap ? H10 : W10;
    assign w_lh        = w_swap ? W10 : H10;
    assign w_in_bounds = !i_pixel_x[9] && !i_pixel_y[9] &&
                         (i_pixel_x < w_lw) && (i_pixel_y < w_lh);

    always_comb begin
        unique case (i_cfg.rotation)
            ROT_0: begin
                w_px = i_pixel_x;
                w_py = i_pixel_y;
            end
            ROT_90: begin
                w_px = W10 - 10'd1 - i_pixel_y;
                w_py = i_pixel_x;
            end
            ROT_180: begin
                w_px = W10 - 10'd1 - i_pixel_x;
                w_py = H10 - 10'd1 - i_pixel_y;
            end
            ROT_270: begin
                w_px = i_pixel_y;
                w_py = H10 - 10'd1 - i_pixel_x;
            end
            default: begin
                w_px = i_pixel_x;
                w_py = i_pixel_y;
            end
        endcase
    end

    // byte index = page * WIDTH + column
    assign w_pix_sum  = W12 * {8'd0, w_py[6:3]} + {4'd0, w_px[7:0]};
    assign w_pix_idx  = w_pix_sum[AW-1:0];
    assign w_pix_mask = 8'd1 << w_py[2:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.pix_issue) begin
            r_pix_addr   <= w_pix_idx;
            r_pix_mask   <= w_pix_mask;
            r_pix_colour <= i_colour;
        end
    end

    always_comb begin
        unique case (r_pix_colour)
            COL_CLEAR:  w_modified = r_rd_data & ~r_pix_mask;
            COL_SET:    w_modified = r_rd_data | r_pix_mask;
            COL_TOGGLE: w_modified = r_rd_data ^ r_pix_mask;
            COL_KEEP:   w_modified = r_rd_data;
            default:    w_modified = r_rd_data;
        endcase
    end

    // ------------------------------------------------------------------
    // Clear sweep pointer, wraps to zero after the last byte
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr_addr <= (r_clr_addr == CLR_LAST) ? '0 : r_clr_addr + AW'(1);
        end
    end

    // ------------------------------------------------------------------
    // Store ports: one write, one registered read
    // ------------------------------------------------------------------
    assign w_we    = i_cmd.clr_step | i_cmd.pix_commit;
    assign w_waddr = i_cmd.clr_step ? r_clr_addr : r_pix_addr;
    assign w_wdata = i_cmd.clr_step ? 8'd0 : w_modified;
    assign w_re    = i_cmd.pix_issue | i_cmd.tick_issue;
    assign w_raddr = i_cmd.pix_issue ? w_pix_idx : w_fl_idx;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Flush geometry: visible page rows [rlo, rend), columns [clo, chi)
    // ------------------------------------------------------------------
    assign w_yo_neg     = i_cfg.y_offset[7];
    assign w_yo_mag     = 9'd0 - {i_cfg.y_offset[7], i_cfg.y_offset};
    assign w_rlo_sum    = w_yo_mag + 9'd7;
    assign w_rlo        = w_yo_neg ? w_rlo_sum[7:3] : 5'd0;
    assign w_hdiff      = H10 - {{2{i_cfg.y_offset[7]}}, i_cfg.y_offset};
    assign w_hceil_sum  = w_hdiff + 10'd7;
    assign w_hceil      = (w_hdiff[9] || w_hdiff == 10'd0) ? 6'd0 : w_hceil_sum[8:3];
    assign w_rend       = (w_hceil < NPAGES6) ? w_hceil : NPAGES6;
    assign w_start_ok   = {1'b0, w_rlo} < w_rend;
    assign w_page_start = w_yo_neg ? 4'd0 : i_cfg.y_offset[6:3];

    assign w_xo_neg   = i_cfg.x_offset[8];
    assign w_clo      = w_xo_neg ? (9'd0 - i_cfg.x_offset) : 9'd0;
    assign w_chi      = w_xo_neg ? W10 : (W10 - {i_cfg.x_offset[8], i_cfg.x_offset});
    assign w_col_addr = w_xo_neg ? 8'd0 : i_cfg.x_offset[7:0];

    // next visible column and next row
    assign w_from  = (r_phase == PH_PAGE) ? 9'd0 : ({1'b0, r_col} + 9'd1);
    assign w_c     = (w_from > w_clo) ? w_from : w_clo;
    assign w_c_ok  = !w_chi[9] && ({1'b0, w_c} < w_chi);
    assign w_rnext = {1'b0, r_row} + 5'd1;
    assign w_r_ok  = {1'b0, w_rnext} < w_rend;
    assign w_last  = (r_phase == PH_PAGE || r_phase == PH_DATA) && !w_c_ok && !w_r_ok;

    assign w_fl_sum = W12 * {8'd0, r_row} + {4'd0, r_col};
    assign w_fl_idx = w_fl_sum[AW-1:0];

    // Beat contents for the current flush position
    always_comb begin
        w_is_cmd = 1'b1;
        unique case (r_phase)
            PH_COL_LOW:  w_byte = i_cfg.col_low_code  | {4'd0, w_col_addr[3:0]};
            PH_COL_HIGH: w_byte = i_cfg.col_high_code | {4'd0, w_col_addr[7:4]};
            PH_PAGE:     w_byte = i_cfg.page_code     | {4'd0, r_page_cnt};
            PH_DATA: begin
                w_byte   = r_rd_data;
                w_is_cmd = 1'b0;
            end
            default:     w_byte = r_rd_data;
        endcase
    end

    // Flush position registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flush_active <= 1'b0;
            r_row          <= 4'd0;
            r_col          <= 8'd0;
            r_phase        <= PH_COL_LOW;
            r_page_cnt     <= 4'd0;
        end else if (i_cmd.flush_start) begin
            r_flush_active <= w_start_ok;
            r_row          <= w_rlo[3:0];
            r_col          <= 8'd0;
            r_phase        <= PH_COL_LOW;
            r_page_cnt     <= w_page_start;
        end else if (i_cmd.tick_emit) begin
            if (r_phase == PH_PAGE) begin
                r_page_cnt <= r_page_cnt + 4'd1;
            end
            priority if (r_phase == PH_COL_LOW) begin
                r_phase <= PH_COL_HIGH;
            end else if (r_phase == PH_COL_HIGH) begin
                r_phase <= PH_PAGE;
            end else if (w_c_ok) begin
                r_phase <= PH_DATA;
                r_col   <= w_c[7:0];
            end else if (w_r_ok) begin
                r_row   <= w_rnext[3:0];
                r_phase <= PH_COL_LOW;
                r_col   <= 8'd0;
            end else begin
                r_flush_active <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.tick_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_emit) begin
            r_out_byte <= w_byte;
            r_out_cmd  <= w_is_cmd;
            r_out_last <= w_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_out_byte   = r_out_byte;
    assign o_is_command = r_out_cmd;
    assign o_last       = r_out_last;

    // Status to controller
    assign o_stat.pix_hit      = w_in_bounds && (i_colour != COL_KEEP);
    assign o_stat.clr_last     = (r_clr_addr == CLR_LAST);
    assign o_stat.flush_active = r_flush_active;
    assign o_stat.out_free     = !r_out_valid || !i_stall;

    // Assertions
    a_emit_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_emit |=> r_out_valid)
        else $error("emitted beat did not reach the output register");

    a_last_ends_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.tick_emit && w_last) |=> !r_flush_active)
        else $error("flush still active after its last beat");

    a_commit_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.pix_commit |-> $past(i_cmd.pix_issue))
        else $error("pixel write-back without a preceding read");

endmodule
